>>> src/rotated_spiral_matrix_element_core_assert.svh
// Assertion macros shared by the rotated spiral element checker
`ifndef ROTATED_SPIRAL_MATRIX_ELEMENT_CORE_ASSERT_SVH
`define ROTATED_SPIRAL_MATRIX_ELEMENT_CORE_ASSERT_SVH

// Same-cycle implication, quiet while reset is high
`define RSME_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high
`define RSME_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/rsme_pkg.sv
// Types and constants of the rotated spiral matrix element core
package rsme_pkg;

   localparam int COORD_W     = 4;
   localparam int SIDE_W      = 5;
   localparam int TURN_W      = 2;
   localparam int VALUE_W     = 9;
   localparam int SQ_W        = 2 * SIDE_W;
   localparam int OFF_W       = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = SIDE_W;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SIDE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_TURNS = 1'b1;

   // Clockwise quarter-turn codes
   localparam logic [TURN_W-1:0] TURN_NONE  = 2'd0;
   localparam logic [TURN_W-1:0] TURN_ONE   = 2'd1;
   localparam logic [TURN_W-1:0] TURN_TWO   = 2'd2;
   localparam logic [TURN_W-1:0] TURN_THREE = 2'd3;

   // Stage 1: side in use and unrotated coordinates
   typedef struct packed {
      logic [SIDE_W-1:0] n;
      logic [SIDE_W-1:0] i;
      logic [SIDE_W-1:0] j;
      logic              in_range;
   } unrot_type;

   // Stage 2: ring index, ring side and n squared
   typedef struct packed {
      logic [SIDE_W-1:0] n;
      logic [SIDE_W-1:0] i;
      logic [SIDE_W-1:0] j;
      logic [SIDE_W-1:0] t;
      logic [SIDE_W-1:0] m;
      logic [SQ_W-1:0]   nsq;
      logic              in_range;
   } ring_type;

   // Stage 3: the two squares and the offset within the ring
   typedef struct packed {
      logic [SQ_W-1:0]  nsq;
      logic [SQ_W-1:0]  msq;
      logic [OFF_W-1:0] off;
      logic             in_range;
   } offset_type;

   // Stage 4: finished result
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               in_range;
   } result_type;

endpackage

>>> src/rotated_spiral_matrix_element_core.sv
// Top level of the rotated spiral matrix element core
//
// Usage:
//   req_* carries one query (row, col); rsp_* returns one result per query,
//   in order: the spiral number and an in-range flag.
//   csr_* writes the side (index 0) and the clockwise quarter-turn count
//   (index 1); write only while no query is in flight.
// Throughput: one query per cycle while rsp_tready is high; four register
//   stages (unrotate, ring, offset with the two squares, final sum) each take
//   a new item whenever they are empty or their successor takes theirs.
// Stall: while rsp_tready is low the result holds on rsp_tdata/rsp_tuser;
//   the stages behind it keep filling and req_tready drops only once every
//   stage holds an item. Nothing is lost or repeated.
// Reset (synchronous): all stages empty, side = 1, quarter turns = 0.
// Sides above MAX_SIDE are used as MAX_SIDE; a side of zero makes every
//   query out of range (value 0, flag clear).
module rotated_spiral_matrix_element_core #(
   parameter int MAX_SIDE = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // Query channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rsme_pkg::REQ_TDATA_W-1:0] req_tdata,  // [3:0] row, [7:4] col
   // Result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rsme_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [8:0] value, [15:9] zero
   output logic                             rsp_tuser,  // [0] in_range
   // Register writes
   input  logic                             csr_we,
   input  logic [rsme_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rsme_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rsme_pkg::*;

   logic [SIDE_W-1:0] side_ff;
   logic [TURN_W-1:0] quarter_turns_ff;

   logic       s1_valid;
   logic       s1_ready;
   unrot_type  s1_data;
   logic       s2_valid;
   logic       s2_ready;
   ring_type   s2_data;
   logic       s3_valid;
   logic       s3_ready;
   offset_type s3_data;
   result_type s4_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff          <= SIDE_W'(1);
         quarter_turns_ff <= TURN_NONE;
      end else if (csr_we) begin
         case (csr_index)
            REG_SIDE:  side_ff          <= csr_wdata[SIDE_W-1:0];
            REG_TURNS: quarter_turns_ff <= csr_wdata[TURN_W-1:0];
            default:   ;
         endcase
      end
   end

   rsme_unrotate #(
      .MAX_SIDE(MAX_SIDE)
   ) u_unrotate (
      .clock         (clock),
      .reset         (reset),
      .side          (side_ff),
      .quarter_turns (quarter_turns_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .row           (req_tdata[COORD_W-1:0]),
      .col           (req_tdata[2*COORD_W-1:COORD_W]),
      .out_valid     (s1_valid),
      .out_ready     (s1_ready),
      .out_data      (s1_data)
   );

   rsme_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   rsme_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   rsme_assemble u_assemble (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (s4_data)
   );

   // Result packing
   assign rsp_tdata = {{(RSP_TDATA_W-VALUE_W){1'b0}}, s4_data.value};
   assign rsp_tuser = s4_data.in_range;

endmodule

>>> src/rsme_unrotate.sv
// Stage 1: saturate the side, check range and undo the rotation
module rsme_unrotate #(
   parameter int MAX_SIDE = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rsme_pkg::SIDE_W-1:0]  side,
   input  logic [rsme_pkg::TURN_W-1:0]  quarter_turns,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [rsme_pkg::COORD_W-1:0] row,
   input  logic [rsme_pkg::COORD_W-1:0] col,
   output logic                         out_valid,
   input  logic                         out_ready,
   output rsme_pkg::unrot_type          out_data
);
   import rsme_pkg::*;

   localparam logic [6:0] SIDE_CAP = 7'(MAX_SIDE);

   logic            valid_ff;
   unrot_type       data_ff;
   unrot_type       data_in;
   logic [6:0]      side_ext;
   logic [SIDE_W-1:0] n;
   logic [SIDE_W-1:0] nm1;
   logic [SIDE_W-1:0] r5;
   logic [SIDE_W-1:0] c5;

   // Side in use, range check and inverse rotation
   always_comb begin
      side_ext = {2'b00, side};
      n        = (side_ext > SIDE_CAP) ? SIDE_CAP[SIDE_W-1:0] : side;
      nm1      = n - SIDE_W'(1);
      r5       = {1'b0, row};
      c5       = {1'b0, col};
      data_in.n        = n;
      data_in.in_range = (n != '0) && (r5 < n) && (c5 < n);
      case (quarter_turns)
         TURN_ONE: begin
            data_in.i = nm1 - c5;
            data_in.j = r5;
         end
         TURN_TWO: begin
            data_in.i = nm1 - r5;
            data_in.j = nm1 - c5;
         end
         TURN_THREE: begin
            data_in.i = c5;
            data_in.j = nm1 - r5;
         end
         default: begin
            data_in.i = r5;
            data_in.j = c5;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/rsme_ring.sv
// Stage 2: ring index, ring side and the square of the full side
module rsme_ring (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rsme_pkg::unrot_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output rsme_pkg::ring_type  out_data
);
   import rsme_pkg::*;

   logic              valid_ff;
   ring_type          data_ff;
   ring_type          data_in;
   logic [SIDE_W-1:0] nm1;
   logic [SIDE_W-1:0] ri;
   logic [SIDE_W-1:0] rj;
   logic [SIDE_W-1:0] min_a;
   logic [SIDE_W-1:0] min_b;
   logic [SIDE_W-1:0] t;

   // Distance to the nearest edge picks the ring
   always_comb begin
      nm1   = in_data.n - SIDE_W'(1);
      ri    = nm1 - in_data.i;
      rj    = nm1 - in_data.j;
      min_a = (in_data.i < in_data.j) ? in_data.i : in_data.j;
      min_b = (ri < rj) ? ri : rj;
      t     = (min_a < min_b) ? min_a : min_b;
      data_in.n        = in_data.n;
      data_in.i        = in_data.i;
      data_in.j        = in_data.j;
      data_in.t        = t;
      data_in.m        = in_data.n - {t[SIDE_W-2:0], 1'b0};
      data_in.nsq      = {{SIDE_W{1'b0}}, in_data.n} * {{SIDE_W{1'b0}}, in_data.n};
      data_in.in_range = in_data.in_range;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/rsme_offset.sv
// Stage 3: square of the ring side and position along the ring
module rsme_offset (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rsme_pkg::ring_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rsme_pkg::offset_type out_data
);
   import rsme_pkg::*;

   logic              valid_ff;
   offset_type        data_ff;
   offset_type        data_in;
   logic [SIDE_W-1:0] hi;
   logic [7:0]        i8;
   logic [7:0]        j8;
   logic [7:0]        t8;
   logic [7:0]        m8;
   logic [7:0]        hi8;
   logic [7:0]        off8;

   // Walk: up the right column, left on top, down the left, right on the bottom
   always_comb begin
      hi  = in_data.n - SIDE_W'(1) - in_data.t;
      i8  = {3'b000, in_data.i};
      j8  = {3'b000, in_data.j};
      t8  = {3'b000, in_data.t};
      m8  = {3'b000, in_data.m};
      hi8 = {3'b000, hi};
      if (in_data.j == hi) begin
         off8 = hi8 - i8;
      end else if (in_data.i == in_data.t) begin
         off8 = m8 + hi8 - 8'd1 - j8;
      end else if (in_data.j == in_data.t) begin
         off8 = {m8[6:0], 1'b0} - 8'd2 + i8 - t8;
      end else begin
         off8 = m8 + {m8[6:0], 1'b0} - 8'd3 + j8 - t8;
      end
      data_in.nsq      = in_data.nsq;
      data_in.msq      = {{SIDE_W{1'b0}}, in_data.m} * {{SIDE_W{1'b0}}, in_data.m};
      data_in.off      = off8[OFF_W-1:0];
      data_in.in_range = in_data.in_range;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/rsme_assemble.sv
// Stage 4: final sum, out-of-range zeroing and the output register
module rsme_assemble (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rsme_pkg::offset_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rsme_pkg::result_type out_data
);
   import rsme_pkg::*;

   logic            valid_ff;
   result_type      data_ff;
   result_type      data_in;
   logic [SQ_W-1:0] sum;

   // Cells before this ring, plus position in it, counted from one
   always_comb begin
      sum = in_data.nsq - in_data.msq + {{(SQ_W-OFF_W){1'b0}}, in_data.off} + SQ_W'(1);
      data_in.value    = in_data.in_range ? sum[VALUE_W-1:0] : '0;
      data_in.in_range = in_data.in_range;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/rsme_checker.sv
// Port-level checker for the rotated spiral matrix element core, with its bind
`include "rotated_spiral_matrix_element_core_assert.svh"

module rsme_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [rsme_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rsme_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             csr_we,
   input logic [rsme_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [rsme_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rsme_pkg::*;

   // A stalled result stays put
   `RSME_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // An out-of-range result carries value zero
   `RSME_ASSERT_NOW(a_oor_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "out-of-range result with nonzero value")

   // A ready sink means the pipeline can take a query every cycle
   `RSME_ASSERT_NOW(a_full_rate, rsp_tready, req_tready, "query stalled while result side is ready")

   // Pipeline comes out of reset empty
   `RSME_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_tvalid, "result valid right after reset")

   // Ports outside the checks above, tied in for completeness of the bind
   logic unused_ports;
   assign unused_ports = req_tvalid ^ (^req_tdata) ^ csr_we ^ (^csr_index) ^ (^csr_wdata);

endmodule

bind rotated_spiral_matrix_element_core rsme_checker u_rsme_checker (.*);

>>> dv/rotated_spiral_matrix_element_core_tb.sv
// Testbench for the rotated spiral matrix element core: directed probes, then random queries
module rotated_spiral_matrix_element_core_tb;
   import rsme_pkg::*;

   localparam int MAX_SIDE_TB   = 16;
   localparam int HOLD_CYCLES   = 60;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int BLOCKS        = 12;
   localparam int BLOCK_ITEMS   = 142;
   localparam int MAX_REPORTS   = 10;

   // One directed probe: setting, query and, where typed in, the result
   typedef struct packed {
      logic [SIDE_W-1:0]  side;
      logic [TURN_W-1:0]  turns;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               typed;
      logic [VALUE_W-1:0] value;
      logic               in_range;
   } probe_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_SIDE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Shadow registers and the store of expected results
   logic [SIDE_W-1:0] cur_side  = 5'd1;
   logic [TURN_W-1:0] cur_turns = TURN_NONE;
   result_type        pending_results[$];

   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   int hold_seq      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int mismatch_count   = 0;
   int queries_sent     = 0;
   int results_in_range = 0;
   int results_outside  = 0;
   int settings_applied = 0;
   int quiet_cycles     = 0;

   probe_type directed_tbl [25] = '{
      '{5'd1,  TURN_NONE,  4'd0,  4'd0,  1'b1, 9'd1,   1'b1},  // reset setting, lone cell
      '{5'd1,  TURN_NONE,  4'd15, 4'd15, 1'b1, 9'd0,   1'b0},
      '{5'd1,  TURN_NONE,  4'd0,  4'd1,  1'b1, 9'd0,   1'b0},
      '{5'd16, TURN_NONE,  4'd15, 4'd15, 1'b1, 9'd1,   1'b1},  // spiral start
      '{5'd16, TURN_NONE,  4'd0,  4'd15, 1'b1, 9'd16,  1'b1},  // top of right column
      '{5'd16, TURN_NONE,  4'd0,  4'd0,  1'b1, 9'd31,  1'b1},
      '{5'd16, TURN_NONE,  4'd15, 4'd0,  1'b1, 9'd46,  1'b1},
      '{5'd16, TURN_NONE,  4'd15, 4'd14, 1'b1, 9'd60,  1'b1},  // end of outer ring
      '{5'd16, TURN_NONE,  4'd8,  4'd7,  1'b1, 9'd256, 1'b1},  // largest value
      '{5'd16, TURN_NONE,  4'd5,  4'd10, 1'b0, 9'd0,   1'b0},
      '{5'd16, TURN_ONE,   4'd0,  4'd0,  1'b0, 9'd0,   1'b0},
      '{5'd16, TURN_ONE,   4'd15, 4'd15, 1'b0, 9'd0,   1'b0},
      '{5'd16, TURN_TWO,   4'd0,  4'd0,  1'b1, 9'd1,   1'b1},  // half turn moves the start
      '{5'd16, TURN_TWO,   4'd9,  4'd3,  1'b0, 9'd0,   1'b0},
      '{5'd16, TURN_THREE, 4'd15, 4'd0,  1'b0, 9'd0,   1'b0},
      '{5'd16, TURN_THREE, 4'd6,  4'd12, 1'b0, 9'd0,   1'b0},
      '{5'd0,  TURN_NONE,  4'd0,  4'd0,  1'b1, 9'd0,   1'b0},  // side zero
      '{5'd0,  TURN_THREE, 4'd15, 4'd15, 1'b1, 9'd0,   1'b0},
      '{5'd31, TURN_NONE,  4'd15, 4'd15, 1'b1, 9'd1,   1'b1},  // side saturates
      '{5'd17, TURN_ONE,   4'd0,  4'd15, 1'b0, 9'd0,   1'b0},
      '{5'd15, TURN_NONE,  4'd14, 4'd14, 1'b1, 9'd1,   1'b1},
      '{5'd15, TURN_NONE,  4'd15, 4'd14, 1'b1, 9'd0,   1'b0},
      '{5'd15, TURN_TWO,   4'd7,  4'd7,  1'b1, 9'd225, 1'b1},  // odd side center
      '{5'd2,  TURN_ONE,   4'd0,  4'd0,  1'b0, 9'd0,   1'b0},
      '{5'd2,  TURN_THREE, 4'd1,  4'd1,  1'b0, 9'd0,   1'b0}
   };

   rotated_spiral_matrix_element_core #(
      .MAX_SIDE (MAX_SIDE_TB)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Spiral number seen at (row, col) of the rotated matrix
   function automatic result_type spiral_lookup(logic [SIDE_W-1:0] side_reg,
                                                logic [TURN_W-1:0] turns,
                                                logic [COORD_W-1:0] row,
                                                logic [COORD_W-1:0] col);
      int unsigned n, r, c, pr, t, lo, hi, m, ring_base, off;
      result_type res;
      n   = (side_reg > MAX_SIDE_TB) ? MAX_SIDE_TB : side_reg;
      r   = row;
      c   = col;
      res = '0;
      if (n == 0 || r >= n || c >= n) return res;
      // undo the clockwise turns: (i, j) went to (j, n-1-i)
      repeat (turns) begin
         pr = n - 1 - c;
         c  = r;
         r  = pr;
      end
      t = r < c ? r : c;
      if (n - 1 - r < t) t = n - 1 - r;
      if (n - 1 - c < t) t = n - 1 - c;
      lo = t;
      hi = n - 1 - t;
      m  = n - 2 * t;
      ring_base = n * n - m * m;
      // ring walk: up the right column, left, down, then right
      if (c == hi)       off = hi - r;
      else if (r == lo)  off = m + (hi - 1 - c);
      else if (c == lo)  off = 2 * m - 1 + (r - lo - 1);
      else               off = 3 * m - 2 + (c - lo - 1);
      res.value    = VALUE_W'(ring_base + off + 1);
      res.in_range = 1'b1;
      return res;
   endfunction

   // Offer one query after a random gap; record its result once taken
   task automatic send_query(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                             result_type want);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {col, row};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(want);
      queries_sent++;
   endtask

   // Stop offering and wait until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Write both registers on back-to-back cycles; block must be idle
   task automatic apply_setting(logic [SIDE_W-1:0] side_val, logic [CSR_DATA_W-1:0] turns_wd);
      csr_we    <= 1'b1;
      csr_index <= REG_SIDE;
      csr_wdata <= side_val;
      @(posedge clock);
      csr_index <= REG_TURNS;
      csr_wdata <= turns_wd;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_side  = side_val;
      cur_turns = turns_wd[TURN_W-1:0];
      settings_applied++;
   endtask

   // Result side: check each taken item, then pick next ready
   always @(posedge clock) begin : result_checker
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result: tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
            end else begin
               want = pending_results.pop_front();
               if (want.in_range) results_in_range++;
               else results_outside++;
               if (rsp_tdata !== {{(RSP_TDATA_W-VALUE_W){1'b0}}, want.value} ||
                   rsp_tuser !== want.in_range) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("mismatch: value exp %0d got %0d (tdata %h), in_range exp %b got %b",
                              want.value, rsp_tdata[VALUE_W-1:0], rsp_tdata,
                              want.in_range, rsp_tuser);
               end
            end
         end
         // long hold-off on request, else random stalls
         if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Watchdog: too long without any item or register write moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("watchdog expired with %0d results outstanding", pending_results.size());
         $display("rotated_spiral_matrix_element_core test failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [SIDE_W-1:0]     block_side [BLOCKS];
      logic [TURN_W-1:0]     turn_code [4];
      logic [COORD_W-1:0]    row, col;
      logic [2:0]            pad;
      logic [CSR_DATA_W-1:0] turns_wd;
      result_type            want;
      int unsigned           n_eff;
      block_side = '{5'd16, 5'd16, 5'd0, 5'd31, 5'd16, 5'd5, 5'd16, 5'd17,
                     5'd1, 5'd16, 5'd11, 5'd16};
      turn_code  = '{TURN_NONE, TURN_ONE, TURN_TWO, TURN_THREE};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 11;
      rcv_idle_pct  = 56;

      // directed probes
      foreach (directed_tbl[k]) begin
         if (directed_tbl[k].side != cur_side || directed_tbl[k].turns != cur_turns) begin
            drain_results();
            apply_setting(directed_tbl[k].side, CSR_DATA_W'(directed_tbl[k].turns));
         end
         if (directed_tbl[k].typed) begin
            want.value    = directed_tbl[k].value;
            want.in_range = directed_tbl[k].in_range;
         end else begin
            want = spiral_lookup(cur_side, cur_turns, directed_tbl[k].row, directed_tbl[k].col);
         end
         send_query(directed_tbl[k].row, directed_tbl[k].col, want);
      end

      // random blocks, one setting each; idling pattern changes every four
      for (int blk = 0; blk < BLOCKS; blk++) begin
         if (blk < 4) begin
            send_idle_pct = 11;
            rcv_idle_pct  = 56;
         end else if (blk < 8) begin
            send_idle_pct = 56;
            rcv_idle_pct  = 11;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         drain_results();
         pad      = 3'($urandom_range(0, 7));
         turns_wd = {pad, turn_code[blk % 4]};
         if (blk == BLOCKS - 1)
            apply_setting(SIDE_W'($urandom_range(1, 16)), turns_wd);
         else
            apply_setting(block_side[blk], turns_wd);
         n_eff = (cur_side > MAX_SIDE_TB) ? MAX_SIDE_TB : cur_side;

         for (int k = 0; k < BLOCK_ITEMS; k++) begin
            // receiver stalls long while queries keep coming
            if (k == 40 && blk % 4 == 0) hold_seq++;
            // sender pause until everything is back
            if (k == 90 && blk % 4 == 1) drain_results();
            if (n_eff > 0 && $urandom_range(99) < 80) begin
               row = COORD_W'($urandom_range(0, n_eff - 1));
               col = COORD_W'($urandom_range(0, n_eff - 1));
            end else begin
               row = COORD_W'($urandom_range(0, 15));
               col = COORD_W'($urandom_range(0, 15));
            end
            send_query(row, col, spiral_lookup(cur_side, cur_turns, row, col));
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) mismatch_count += pending_results.size();

      $display("%0d queries over %0d register settings: %0d in range, %0d outside",
               queries_sent, settings_applied, results_in_range, results_outside);
      $display("sides 0, 1, 2, 5, 11, 15, 16 and saturated, all four turn counts, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("rotated_spiral_matrix_element_core test passed");
      end else begin
         $display("rotated_spiral_matrix_element_core test failed");
      end
      $finish;
   end

endmodule
